/* hw/rtl/spvg_pkg.sv */
package spvg_pkg;

	localparam int CfgIdxW = 3;
	localparam int GridW = 9;
	localparam int FadeW = 17;

	localparam logic [CfgIdxW-1:0] CfgGridDivisions = 3'd0;
	localparam logic [CfgIdxW-1:0] CfgPlanetRadius = 3'd1;
	localparam logic [CfgIdxW-1:0] CfgAtmosphereRadius = 3'd2;
	localparam logic [CfgIdxW-1:0] CfgHorizontalTile = 3'd3;
	localparam logic [CfgIdxW-1:0] CfgVerticalTile = 3'd4;
	localparam logic [CfgIdxW-1:0] CfgFadePercent = 3'd5;
	localparam logic [CfgIdxW-1:0] CfgCubicFade = 3'd6;

	localparam logic [GridW-1:0] MaxDivisions = 9'd256;
	localparam logic [FadeW-1:0] FadeOne = 17'd65536;

	localparam logic [GridW-1:0] RstGridDivisions = 9'd16;
	localparam logic [31:0] RstPlanetRadius = 32'd65536000;
	localparam logic [31:0] RstAtmosphereRadius = 32'd6553600;
	localparam logic [31:0] RstHorizontalTile = 32'd65536;
	localparam logic [31:0] RstVerticalTile = 32'd65536;
	localparam logic [FadeW-1:0] RstFadePercent = 17'd65536;

	// grid scaling divide: 9-bit index times 32-bit value over a 9-bit divisor
	localparam int GridQw = 41;
	localparam int GridDw = 9;
	// Q0.32 fraction divide over a 64-bit denominator
	localparam int FracQw = 32;
	localparam int FracDw = 64;

	// derived-constant sequencer
	localparam logic [2:0] SqRr = 3'd0;
	localparam logic [2:0] SqInit = 3'd1;
	localparam logic [2:0] SqSqrt = 3'd2;
	localparam logic [2:0] SqFr = 3'd3;
	localparam logic [2:0] SqA2 = 3'd4;
	localparam logic [2:0] SqIdle = 3'd5;

endpackage

/* hw/rtl/sky_plane_vertex_generator.sv */
// Throughput: one vertex per cycle while the constant sequencer is idle; the 41-stage grid
// divider and the 32-stage fraction divider are fully pipelined, and the whole pipe holds only
// while a result is stalled. Reset clears all valid bits and loads the register defaults, then
// the constant sequencer runs (also after every config write) with in_stall high.
module sky_plane_vertex_generator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [8:0]  grid_row,
	input  logic [8:0]  grid_col,
	output logic        out_valid,
	input  logic        out_stall,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [31:0] pos_z,
	output logic [16:0] fade_alpha,
	output logic [31:0] tex_u,
	output logic [31:0] tex_v,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	function automatic logic [31:0] sat_signed(input logic [31:0] mag, input logic neg);
		logic [31:0] r;
		if (neg) begin
			r = mag[31] ? 32'h8000_0000 : 32'(33'd0 - 33'(mag));
		end else begin
			r = mag[31] ? 32'h7FFF_FFFF : mag;
		end
		return r;
	endfunction

	// configuration registers
	logic [8:0]  div_q;
	logic [31:0] rad_q;
	logic [31:0] atm_q;
	logic [31:0] htile_q;
	logic [31:0] vtile_q;
	logic [16:0] fpct_q;
	logic        cubic_q;

	// derived constants
	logic [2:0]  seq_q;
	logic [63:0] rr_q;
	logic [63:0] sv_q;
	logic [63:0] res_q;
	logic [63:0] bit_q;
	logic [31:0] hs_q;
	logic [31:0] fr_q;
	logic [63:0] a2_q;

	logic        busy;
	logic        en;
	logic        cfg_wr;
	logic [8:0]  dv;
	logic [16:0] pv;

	assign cfg_ready = 1'b1;
	assign cfg_wr = cfg_valid && cfg_ready;
	assign busy = (seq_q != spvg_pkg::SqIdle);
	assign en = !(out_valid && out_stall);
	assign in_stall = !en || busy;

	always_comb begin
		if (div_q == 9'd0) dv = 9'd1;
		else if (div_q > spvg_pkg::MaxDivisions) dv = spvg_pkg::MaxDivisions;
		else dv = div_q;
		pv = (fpct_q > spvg_pkg::FadeOne) ? spvg_pkg::FadeOne : fpct_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_q <= spvg_pkg::RstGridDivisions;
			rad_q <= spvg_pkg::RstPlanetRadius;
			atm_q <= spvg_pkg::RstAtmosphereRadius;
			htile_q <= spvg_pkg::RstHorizontalTile;
			vtile_q <= spvg_pkg::RstVerticalTile;
			fpct_q <= spvg_pkg::RstFadePercent;
			cubic_q <= 1'b0;
			seq_q <= spvg_pkg::SqRr;
		end else begin
			if (cfg_wr) begin
				unique case (cfg_index)
					spvg_pkg::CfgGridDivisions: div_q <= cfg_data[8:0];
					spvg_pkg::CfgPlanetRadius: rad_q <= cfg_data;
					spvg_pkg::CfgAtmosphereRadius: atm_q <= cfg_data;
					spvg_pkg::CfgHorizontalTile: htile_q <= cfg_data;
					spvg_pkg::CfgVerticalTile: vtile_q <= cfg_data;
					spvg_pkg::CfgFadePercent: fpct_q <= cfg_data[16:0];
					spvg_pkg::CfgCubicFade: cubic_q <= cfg_data[0];
					default: ;
				endcase
				seq_q <= spvg_pkg::SqRr;
			end else begin
				unique case (seq_q)
					spvg_pkg::SqRr: seq_q <= spvg_pkg::SqInit;
					spvg_pkg::SqInit: seq_q <= spvg_pkg::SqSqrt;
					spvg_pkg::SqSqrt: if (bit_q[0]) seq_q <= spvg_pkg::SqFr;
					spvg_pkg::SqFr: seq_q <= spvg_pkg::SqA2;
					spvg_pkg::SqA2: seq_q <= spvg_pkg::SqIdle;
					default: seq_q <= spvg_pkg::SqIdle;
				endcase
			end
		end
	end

	// r*r, half side = isqrt(r*r/2) by digit-by-digit square root, fade radius fr and a2 = fr*fr
	always_ff @(posedge clk) begin
		unique case (seq_q)
			spvg_pkg::SqRr: rr_q <= 64'(rad_q) * 64'(rad_q);
			spvg_pkg::SqInit: begin
				sv_q <= {1'b0, rr_q[63:1]};
				res_q <= 64'd0;
				bit_q <= 64'h4000_0000_0000_0000;
			end
			spvg_pkg::SqSqrt: begin
				if (sv_q >= res_q + bit_q) begin
					sv_q <= sv_q - (res_q + bit_q);
					res_q <= {1'b0, res_q[63:1]} + bit_q;
				end else begin
					res_q <= {1'b0, res_q[63:1]};
				end
				bit_q <= {2'b00, bit_q[63:2]};
			end
			spvg_pkg::SqFr: begin
				hs_q <= res_q[31:0];
				fr_q <= 32'((49'(res_q[31:0]) * 49'(pv)) >> 16);
			end
			spvg_pkg::SqA2: a2_q <= 64'(fr_q) * 64'(fr_q);
			default: ;
		endcase
	end

	// ---------------- front stages ----------------
	logic       vld_s1, vld_s2, vld_s3;
	logic [8:0] i_s1, j_s1, i_s2, j_s2;
	logic       nx_s2, nz_s2, nx_s3, nz_s3;
	logic [8:0] ax_s2, az_s2;
	logic [40:0] px_s3, pz_s3, pu_s3, pv_s3;
	logic [9:0] i2, j2;

	assign i2 = {i_s1, 1'b0};
	assign j2 = {j_s1, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			i_s1 <= (grid_row > dv) ? dv : grid_row;
			j_s1 <= (grid_col > dv) ? dv : grid_col;

			i_s2 <= i_s1;
			j_s2 <= j_s1;
			nx_s2 <= (j2 < 10'(dv));
			nz_s2 <= (i2 < 10'(dv));
			ax_s2 <= (j2 < 10'(dv)) ? 9'(10'(dv) - j2) : 9'(j2 - 10'(dv));
			az_s2 <= (i2 < 10'(dv)) ? 9'(10'(dv) - i2) : 9'(i2 - 10'(dv));

			nx_s3 <= nx_s2;
			nz_s3 <= nz_s2;
			px_s3 <= 41'(ax_s2) * 41'(hs_q);
			pz_s3 <= 41'(az_s2) * 41'(hs_q);
			pu_s3 <= 41'(htile_q) * 41'(j_s2);
			pv_s3 <= 41'(vtile_q) * 41'(i_s2);
		end
	end

	// ---------------- grid divide by D ----------------
	logic                      gd_valid;
	logic [3:0][spvg_pkg::GridQw-1:0] gd_quot;
	logic [1:0]                gd_side;

	spvg_div #(
		.QW(spvg_pkg::GridQw),
		.DW(spvg_pkg::GridDw),
		.LN(4),
		.SW(2)
	) u_grid_div (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(vld_s3),
		.rem0('0),
		.den({4{dv}}),
		.num({pv_s3, pu_s3, pz_s3, px_s3}),
		.side_in({nx_s3, nz_s3}),
		.out_valid(gd_valid),
		.quot(gd_quot),
		.side_out(gd_side)
	);

	// ---------------- distance squared ----------------
	logic        vld_s4, vld_s5, vld_s6;
	logic [31:0] mx_s4, mz_s4;
	logic [31:0] x_s4, z_s4, u_s4, v_s4;
	logic [31:0] x_s5, z_s5, u_s5, v_s5;
	logic [31:0] x_s6, z_s6, u_s6, v_s6;
	logic [63:0] sqx_s5, sqz_s5;
	logic [64:0] d2_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s4 <= gd_valid;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mx_s4 <= gd_quot[0][31:0];
			mz_s4 <= gd_quot[1][31:0];
			x_s4 <= sat_signed(gd_quot[0][31:0], gd_side[1]);
			z_s4 <= sat_signed(gd_quot[1][31:0], gd_side[0]);
			u_s4 <= gd_quot[2][31:0];
			v_s4 <= gd_quot[3][31:0];

			sqx_s5 <= 64'(mx_s4) * 64'(mx_s4);
			sqz_s5 <= 64'(mz_s4) * 64'(mz_s4);
			x_s5 <= x_s4;
			z_s5 <= z_s4;
			u_s5 <= u_s4;
			v_s5 <= v_s4;

			d2_s6 <= 65'(sqx_s5) + 65'(sqz_s5);
			x_s6 <= x_s5;
			z_s6 <= z_s5;
			u_s6 <= u_s5;
			v_s6 <= v_s5;
		end
	end

	// ---------------- fractions d2/R2 and d2/a2 ----------------
	logic q_zero, q_one, al_zero;

	assign q_zero = (rr_q == 64'd0);
	assign q_one = (d2_s6 >= 65'(rr_q));
	assign al_zero = (d2_s6 >= 65'(a2_q));

	logic                     fd_valid;
	logic [1:0][spvg_pkg::FracQw-1:0] fd_quot;
	logic [130:0]             fd_side;

	spvg_div #(
		.QW(spvg_pkg::FracQw),
		.DW(spvg_pkg::FracDw),
		.LN(2),
		.SW(131)
	) u_frac_div (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(vld_s6),
		.rem0({d2_s6[63:0], d2_s6[63:0]}),
		.den({a2_q, rr_q}),
		.num('0),
		.side_in({q_zero, q_one, al_zero, x_s6, z_s6, u_s6, v_s6}),
		.out_valid(fd_valid),
		.quot(fd_quot),
		.side_out(fd_side)
	);

	// ---------------- height and fade ----------------
	logic        vld_s7, vld_s8, vld_s9;
	logic [32:0] q_s7;
	logic [31:0] t_s7, t_s8, t_s9;
	logic [31:0] tt_s8, t3_s9;
	logic [31:0] aq_s8, y_s9;
	logic        az_s7, az_s8, az_s9;
	logic [127:0] pk_s7, pk_s8, pk_s9;
	logic [31:0] tf;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			vld_s7 <= fd_valid;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
			out_valid <= vld_s9;
		end
	end

	assign tf = cubic_q ? t3_s9 : t_s9;

	always_ff @(posedge clk) begin
		if (en) begin
			priority if (fd_side[130]) q_s7 <= 33'd0;
			else if (fd_side[129]) q_s7 <= 33'h1_0000_0000;
			else q_s7 <= {1'b0, fd_quot[0]};
			t_s7 <= fd_quot[1];
			az_s7 <= fd_side[128];
			pk_s7 <= fd_side[127:0];

			aq_s8 <= 32'((64'(atm_q) * 64'(q_s7)) >> 32);
			tt_s8 <= 32'((64'(t_s7) * 64'(t_s7)) >> 32);
			t_s8 <= t_s7;
			az_s8 <= az_s7;
			pk_s8 <= pk_s7;

			y_s9 <= atm_q - aq_s8;
			t3_s9 <= 32'((64'(tt_s8) * 64'(t_s8)) >> 32);
			t_s9 <= t_s8;
			az_s9 <= az_s8;
			pk_s9 <= pk_s8;

			pos_x <= pk_s9[127:96];
			pos_z <= pk_s9[95:64];
			tex_u <= pk_s9[63:32];
			tex_v <= pk_s9[31:0];
			pos_y <= sat_signed(y_s9, 1'b0);
			fade_alpha <= az_s9 ? 17'd0 : 17'((33'h1_0000_0000 - 33'(tf)) >> 16);
		end
	end

endmodule

/* hw/rtl/spvg_div.sv */
// Pipelined restoring divider, one quotient bit per stage, LN lanes in step; num
// goes MSB first. Callers keep each start remainder below its divisor (unchecked).
module spvg_div #(
	parameter int QW = 32,
	parameter int DW = 64,
	parameter int LN = 2,
	parameter int SW = 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  logic [LN-1:0][DW-1:0]  rem0,
	input  logic [LN-1:0][DW-1:0]  den,
	input  logic [LN-1:0][QW-1:0]  num,
	input  logic [SW-1:0]          side_in,
	output logic                   out_valid,
	output logic [LN-1:0][QW-1:0]  quot,
	output logic [SW-1:0]          side_out
);

	logic                  vld_s  [QW];
	logic [LN-1:0][DW-1:0] rem_s  [QW];
	logic [LN-1:0][DW-1:0] den_s  [QW];
	logic [LN-1:0][QW-1:0] nq_s   [QW];
	logic [SW-1:0]         side_s [QW];

	logic [LN-1:0][DW-1:0] rem_d [QW];
	logic [LN-1:0][QW-1:0] nq_d  [QW];

	always_comb begin
		logic [DW:0]           r2;
		logic                  ge;
		logic [LN-1:0][DW-1:0] prem;
		logic [LN-1:0][DW-1:0] pden;
		logic [LN-1:0][QW-1:0] pnq;
		for (int k = 0; k < QW; k++) begin
			if (k == 0) begin
				prem = rem0;
				pden = den;
				pnq = num;
			end else begin
				prem = rem_s[k-1];
				pden = den_s[k-1];
				pnq = nq_s[k-1];
			end
			for (int l = 0; l < LN; l++) begin
				r2 = {prem[l], pnq[l][QW-1]};
				ge = (r2 >= {1'b0, pden[l]});
				rem_d[k][l] = ge ? DW'(r2 - {1'b0, pden[l]}) : r2[DW-1:0];
				nq_d[k][l] = {pnq[l][QW-2:0], ge};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < QW; k++) vld_s[k] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
			for (int k = 1; k < QW; k++) vld_s[k] <= vld_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < QW; k++) begin
				rem_s[k] <= rem_d[k];
				nq_s[k] <= nq_d[k];
			end
			den_s[0] <= den;
			side_s[0] <= side_in;
			for (int k = 1; k < QW; k++) begin
				den_s[k] <= den_s[k-1];
				side_s[k] <= side_s[k-1];
			end
		end
	end

	assign out_valid = vld_s[QW-1];
	assign quot = nq_s[QW-1];
	assign side_out = side_s[QW-1];

endmodule

/* test/sky_plane_vertex_generator_test.sv */
module sky_plane_vertex_generator_test;

	typedef struct packed {
		logic [8:0] row;
		logic [8:0] col;
	} grid_point_t;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic [16:0] alpha;
		logic [31:0] u;
		logic [31:0] v;
	} vertex_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [8:0] grid_row = '0;
	logic [8:0] grid_col = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] pos_x, pos_y, pos_z;
	logic [16:0] fade_alpha;
	logic [31:0] tex_u, tex_v;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	logic [8:0] divs_reg;
	logic [31:0] radius_reg, atmos_reg, htile_reg, vtile_reg;
	logic [16:0] fade_reg;
	logic cubic_reg;

	grid_point_t pending_points[$];
	vertex_t expected_vertices[$];
	int errors = 0;
	bit in_calm = 1'b0;
	bit out_calm = 1'b0;

	sky_plane_vertex_generator uut (.*);

	always #1 clk = ~clk;

	function automatic logic [63:0] int_sqrt(input logic [63:0] val);
		logic [63:0] res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > val) b >>= 2;
		while (b != 0) begin
			if (val >= res + b) begin
				val -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic logic [63:0] ratio_q32(input logic [63:0] num, input logic [63:0] den);
		logic [127:0] wide;
		if (den == 0) return 0;
		if (num >= den) return 64'd1 << 32;
		wide = {64'd0, num} << 32;
		return 64'(wide / den);
	endfunction

	function automatic logic [31:0] clamp_signed(input logic [63:0] mag, input bit neg);
		if (neg) return (mag >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-mag);
		return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
	endfunction

	function automatic vertex_t sky_vertex(input grid_point_t pt);
		logic [63:0] dv, ri, cj, p, r, hs, ax, az, mx, mz, d2, q, fr, a2, t;
		bit nx, nz;
		vertex_t vx;
		dv = divs_reg;
		ri = pt.row;
		cj = pt.col;
		p = fade_reg;
		r = radius_reg;
		if (dv < 1) dv = 1;
		if (dv > spvg_pkg::MaxDivisions) dv = spvg_pkg::MaxDivisions;
		if (ri > dv) ri = dv;
		if (cj > dv) cj = dv;
		if (p > spvg_pkg::FadeOne) p = spvg_pkg::FadeOne;
		hs = int_sqrt((r * r) >> 1);
		nx = 2 * cj < dv;
		ax = nx ? dv - 2 * cj : 2 * cj - dv;
		mx = ax * hs / dv;
		nz = 2 * ri < dv;
		az = nz ? dv - 2 * ri : 2 * ri - dv;
		mz = az * hs / dv;
		d2 = mx * mx + mz * mz;
		q = ratio_q32(d2, r * r);
		vx.x = clamp_signed(mx, nx);
		vx.y = clamp_signed(atmos_reg - ((atmos_reg * q) >> 32), 1'b0);
		vx.z = clamp_signed(mz, nz);
		fr = (hs * p) >> 16;
		a2 = fr * fr;
		if (d2 >= a2) begin
			vx.alpha = '0;
		end else begin
			t = ratio_q32(d2, a2);
			if (cubic_reg) t = (((t * t) >> 32) * t) >> 32;
			vx.alpha = 17'(((64'd1 << 32) - t) >> 16);
		end
		vx.u = 32'(htile_reg * cj / dv);
		vx.v = 32'(vtile_reg * ri / dv);
		return vx;
	endfunction

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (!in_valid || !in_stall) begin
				if (pending_points.size() > 0 && (in_calm || $urandom_range(99) >= 18)) begin
					grid_point_t pt;
					pt = pending_points.pop_front();
					expected_vertices = {expected_vertices, sky_vertex(pt)};
					in_valid <= 1'b1;
					grid_row <= pt.row;
					grid_col <= pt.col;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_stall <= !out_calm && ($urandom_range(99) < 18);
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_vertices.size() == 0) begin
				$error("unexpected transaction: x %h", pos_x);
				errors++;
			end else begin
				vertex_t e;
				e = expected_vertices.pop_front();
				if (pos_x !== e.x) begin $error("pos_x exp %h got %h", e.x, pos_x); errors++; end
				if (pos_y !== e.y) begin $error("pos_y exp %h got %h", e.y, pos_y); errors++; end
				if (pos_z !== e.z) begin $error("pos_z exp %h got %h", e.z, pos_z); errors++; end
				if (fade_alpha !== e.alpha) begin
					$error("fade_alpha exp %h got %h", e.alpha, fade_alpha); errors++;
				end
				if (tex_u !== e.u) begin $error("tex_u exp %h got %h", e.u, tex_u); errors++; end
				if (tex_v !== e.v) begin $error("tex_v exp %h got %h", e.v, tex_v); errors++; end
			end
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			spvg_pkg::CfgGridDivisions: divs_reg = val[8:0];
			spvg_pkg::CfgPlanetRadius: radius_reg = val;
			spvg_pkg::CfgAtmosphereRadius: atmos_reg = val;
			spvg_pkg::CfgHorizontalTile: htile_reg = val;
			spvg_pkg::CfgVerticalTile: vtile_reg = val;
			spvg_pkg::CfgFadePercent: fade_reg = val[16:0];
			spvg_pkg::CfgCubicFade: cubic_reg = val[0];
			default: ;
		endcase
	endtask

	task automatic drain();
		while (pending_points.size() > 0 || in_valid || expected_vertices.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic add_point(input int r, input int c);
		grid_point_t pt;
		pt.row = 9'(r);
		pt.col = 9'(c);
		pending_points = {pending_points, pt};
	endtask

	task automatic random_points(input int n, input int span);
		repeat (n) begin
			if ($urandom_range(9) == 0) add_point($urandom_range(511), $urandom_range(511));
			else add_point($urandom_range(span), $urandom_range(span));
		end
	endtask

	initial begin
		divs_reg = spvg_pkg::RstGridDivisions;
		radius_reg = spvg_pkg::RstPlanetRadius;
		atmos_reg = spvg_pkg::RstAtmosphereRadius;
		htile_reg = spvg_pkg::RstHorizontalTile;
		vtile_reg = spvg_pkg::RstVerticalTile;
		fade_reg = spvg_pkg::RstFadePercent;
		cubic_reg = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: corners, centre, out-of-grid indexes, all bits
		add_point(0, 0);
		add_point(16, 16);
		add_point(8, 8);
		add_point(0, 16);
		add_point(16, 0);
		add_point(511, 511);
		add_point(17, 3);
		add_point(256, 255);
		add_point(170, 85);
		add_point(85, 170);
		drain();

		write_reg(spvg_pkg::CfgCubicFade, 32'd1);
		write_reg(spvg_pkg::CfgFadePercent, 32'd32768);
		add_point(8, 8);
		add_point(4, 12);
		add_point(0, 0);
		drain();

		// zero radius, zero fade, huge radius saturation, oversized divisions
		write_reg(spvg_pkg::CfgPlanetRadius, 32'd0);
		write_reg(spvg_pkg::CfgFadePercent, 32'd0);
		add_point(3, 9);
		drain();
		write_reg(spvg_pkg::CfgPlanetRadius, 32'hFFFF_FFFF);
		write_reg(spvg_pkg::CfgFadePercent, 32'h1FFFF);
		write_reg(spvg_pkg::CfgGridDivisions, 32'd511);
		write_reg(spvg_pkg::CfgAtmosphereRadius, 32'hFFFF_FFFF);
		write_reg(spvg_pkg::CfgHorizontalTile, 32'hFFFF_FFFF);
		write_reg(spvg_pkg::CfgVerticalTile, 32'hFFFF_FFFF);
		add_point(0, 0);
		add_point(256, 256);
		add_point(128, 0);
		add_point(300, 64);
		drain();
		write_reg(spvg_pkg::CfgGridDivisions, 32'd0);
		add_point(0, 1);
		add_point(1, 0);
		add_point(2, 5);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			int dv;
			dv = (ph == 0) ? 1 : (ph == 1) ? 256 : $urandom_range(2, 64);
			write_reg(spvg_pkg::CfgGridDivisions, 32'(dv));
			write_reg(spvg_pkg::CfgPlanetRadius, (ph == 2) ? 32'd1 : $urandom());
			write_reg(spvg_pkg::CfgAtmosphereRadius, (ph == 3) ? 32'd0 : $urandom());
			write_reg(spvg_pkg::CfgHorizontalTile, (ph == 3) ? 32'd0 : $urandom());
			write_reg(spvg_pkg::CfgVerticalTile, $urandom());
			write_reg(spvg_pkg::CfgFadePercent, (ph == 4) ? 32'd0 : $urandom_range(70000));
			write_reg(spvg_pkg::CfgCubicFade, 32'(ph % 2));
			in_calm = (ph == 2);
			out_calm = (ph == 2);
			random_points(100, dv);
			drain();
		end

		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#200000;
		$display("Simulation FAILED");
		$finish;
	end
endmodule
